// ----- src/prt_pkg.sv -----
// Types, codes and constants for the prescaled reload timer.
// Used by every module of the block; depends on nothing.
package prt_pkg;

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_NONE    = 2'd3
  } prt_mode_t;

  typedef enum logic [1:0] {
    PRE_DIV1    = 2'd0,
    PRE_DIV64   = 2'd1,
    PRE_DIV256  = 2'd2,
    PRE_DIV1024 = 2'd3
  } prt_pre_t;

  localparam int CycleW   = 16;
  localparam int AccW     = 10;
  localparam int TickW    = 17;
  localparam int ModW     = 17;
  localparam int DivSteps = ModW;
  localparam int StepW    = $clog2(DivSteps + 1);
  localparam int EnableBit = 7;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        byte_offset;
    logic [7:0]        write_data;
    logic [CycleW-1:0] cycle_count;
  } prt_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       overflowed;
  } prt_out_t;

  typedef struct packed {
    logic load;        // take a new request
    logic exec;        // read, write, or prescale step of an advance
    logic add;         // add ticks to counter, start remainder on wrap
    logic mod_finish;  // reload plus remainder into counter
    logic push;        // move result into output register
  } prt_cmd_t;

  typedef struct packed {
    prt_mode_t mode;
    logic      adv_skip;
    logic      wrap;
    logic      mod_done;
    logic      out_busy;
  } prt_status_t;

endpackage

// ----- src/prescaled_reload_timer.sv -----
// Prescaled reload timer, top level. Depends on prt_pkg, prt_ctrl, prt_datapath.
// Sequence: every request is loaded, executed and pushed to the result register;
// an advance that steps the counter also runs an add step, and one that wraps
// then waits on the 17-step remainder unit. Only one request is in flight at a
// time, and the push waits while the result register is full. Reset (rst, sync) clears
// counter, reload, control (timer disabled), prescaler and output valid.
module prescaled_reload_timer
  import prt_pkg::*;
#(
  parameter int CYCLE_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  prt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output prt_out_t out_data
);

  localparam logic [CycleW-1:0] CycleMask =
    (CYCLE_BITS >= CycleW) ? {CycleW{1'b1}} : CycleW'((64'd1 << CYCLE_BITS) - 64'd1);

  prt_in_t     item_in;
  prt_cmd_t    cmd;
  prt_status_t status;

  always_comb begin
    item_in             = in_data;
    item_in.cycle_count = in_data.cycle_count & CycleMask;
  end

  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  prt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !(out_valid && !out_ready))
    else $error("result register overwritten before taken");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_valid && in_ready)
    else $error("result push did not free the sequencer");

  a_finish_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_finish |-> status.mod_done && !in_ready)
    else $error("remainder used before it was ready");

endmodule

// ----- src/prt_mod.sv -----
// Iterative remainder unit: one restoring step per cycle.
// Depends on prt_pkg.
module prt_mod
  import prt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [ModW-1:0] dividend,
  input  logic [ModW-1:0] divisor,
  output logic            done,
  output logic [ModW-1:0] remainder
);

  logic [ModW-1:0]  dvd;
  logic [ModW-1:0]  dvs;
  logic [ModW-1:0]  rem;
  logic [StepW-1:0] steps;
  logic             busy;
  logic [ModW:0]    rem_shift;
  logic [ModW:0]    rem_sub;

  assign rem_shift = {rem, dvd[ModW-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= StepW'(DivSteps);
      dvd   <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      dvd <= {dvd[ModW-2:0], 1'b0};
      if (rem_shift >= {1'b0, dvs}) begin
        rem <= rem_sub[ModW-1:0];
      end else begin
        rem <= rem_shift[ModW-1:0];
      end
      steps <= steps - 1'b1;
      if (steps == StepW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- src/prt_datapath.sv -----
// Timer datapath: counter, reload, control, prescale accumulator, result.
// Depends on prt_pkg and prt_mod.
module prt_datapath
  import prt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  prt_in_t     item_in,
  input  prt_cmd_t    cmd,
  output prt_status_t status,
  output logic        out_valid,
  input  logic        out_ready,
  output prt_out_t    out_data
);

  prt_in_t           item;
  logic [15:0]       count_value;
  logic [15:0]       reload_value;
  logic [15:0]       control_word;
  logic [AccW-1:0]   acc;
  logic [TickW-1:0]  ticks;
  prt_out_t          res;

  logic [TickW-1:0]  total;
  logic [TickW-1:0]  ticks_next;
  logic [AccW-1:0]   acc_next;
  logic [15:0]       rd_src;
  logic [7:0]        rd_byte;
  logic [15:0]       count_wr;
  logic [15:0]       control_wr;
  logic [TickW:0]    sum;
  logic [TickW:0]    rest_full;
  logic [ModW-1:0]   period;
  logic              mod_done;
  logic [ModW-1:0]   mod_rem;
  logic [ModW-1:0]   reload_sum;

  assign total = {{(TickW-AccW){1'b0}}, acc} + {{(TickW-CycleW){1'b0}}, item.cycle_count};

  always_comb begin
    case (prt_pre_t'(control_word[1:0]))
      PRE_DIV1: begin
        ticks_next = total;
        acc_next   = '0;
      end
      PRE_DIV64: begin
        ticks_next = total >> 6;
        acc_next   = AccW'(total[5:0]);
      end
      PRE_DIV256: begin
        ticks_next = total >> 8;
        acc_next   = AccW'(total[7:0]);
      end
      default: begin
        ticks_next = total >> 10;
        acc_next   = total[9:0];
      end
    endcase
  end

  assign rd_src  = item.byte_offset[1] ? control_word : count_value;
  assign rd_byte = item.byte_offset[0] ? rd_src[15:8] : rd_src[7:0];

  always_comb begin
    count_wr   = count_value;
    control_wr = control_word;
    if (item.byte_offset[0]) begin
      count_wr[15:8]   = item.write_data;
      control_wr[15:8] = item.write_data;
    end else begin
      count_wr[7:0]   = item.write_data;
      control_wr[7:0] = item.write_data;
    end
  end

  assign sum        = {{(TickW-15){1'b0}}, count_value} + {1'b0, ticks};
  assign rest_full  = sum - (TickW+1)'(17'h10000);
  assign period     = 17'h10000 - {1'b0, reload_value};
  assign reload_sum = {1'b0, reload_value} + mod_rem;

  assign status.mode     = prt_mode_t'(item.mode);
  assign status.adv_skip = !control_word[EnableBit] || (item.cycle_count == '0);
  assign status.wrap     = sum[TickW:16] != '0;
  assign status.mod_done = mod_done;
  assign status.out_busy = out_valid && !out_ready;

  prt_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.add && status.wrap),
    .dividend  (rest_full[ModW-1:0]),
    .divisor   (period),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value  <= '0;
      reload_value <= '0;
      control_word <= '0;
      acc          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.exec) begin
        res <= '{read_data: (prt_mode_t'(item.mode) == MODE_READ) ? rd_byte : 8'h00,
                 overflowed: 1'b0};
        case (prt_mode_t'(item.mode))
          MODE_READ: begin
          end
          MODE_WRITE: begin
            if (item.byte_offset[1]) begin
              control_word <= control_wr;
              acc          <= '0;
              if (control_wr[EnableBit] && !control_word[EnableBit]) begin
                count_value <= reload_value;
              end
            end else begin
              count_value  <= count_wr;
              reload_value <= count_wr;
            end
          end
          MODE_ADVANCE: begin
            if (!status.adv_skip) begin
              ticks <= ticks_next;
              acc   <= acc_next;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.add && !status.wrap) begin
        count_value <= sum[15:0];
      end
      if (cmd.mod_finish) begin
        count_value    <= reload_sum[15:0];
        res.overflowed <= 1'b1;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= item_in;
    end
  end

endmodule

// ----- src/prt_ctrl.sv -----
// Timer sequencer: steps each request through the datapath.
// Depends on prt_pkg.
module prt_ctrl
  import prt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  prt_status_t status,
  output prt_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.mode == MODE_ADVANCE && !status.adv_skip) begin
          state_next = S_ADD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = status.wrap ? S_DIV : S_FINISH;
      end
      S_DIV: begin
        if (status.mod_done) begin
          cmd.mod_finish = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
